// ----- hdl/chacha_pkg.sv -----
package chacha_pkg;

    typedef logic [15:0][31:0] block_t;
    typedef logic [3:0][31:0]  lane_t;

    typedef enum logic [2:0]
    {
        OP_ADD,
        OP_R16,
        OP_R12,
        OP_R8,
        OP_R7
    } qr_op_t;

    typedef struct packed
    {
        logic start;
    } core_ctl_t;

    typedef struct packed
    {
        logic busy;
        logic done;
    } core_sts_t;

    localparam logic [31:0] SIGMA_0 = 32'h61707865;
    localparam logic [31:0] SIGMA_1 = 32'h3320646e;
    localparam logic [31:0] SIGMA_2 = 32'h79622d32;
    localparam logic [31:0] SIGMA_3 = 32'h6b206574;

    localparam logic [2:0] REG_KEY_0      = 3'd0;
    localparam logic [2:0] REG_KEY_1      = 3'd1;
    localparam logic [2:0] REG_KEY_2      = 3'd2;
    localparam logic [2:0] REG_KEY_3      = 3'd3;
    localparam logic [2:0] REG_NONCE_LOW  = 3'd4;
    localparam logic [2:0] REG_NONCE_HIGH = 3'd5;
    localparam logic [2:0] REG_INIT_CTR   = 3'd6;

endpackage

// ----- hdl/chacha_qr_unit.sv -----
module chacha_qr_unit
(
    input  chacha_pkg::qr_op_t op,
    input  chacha_pkg::lane_t  x,
    input  chacha_pkg::lane_t  y,
    input  chacha_pkg::lane_t  z,
    output chacha_pkg::lane_t  sum,
    output chacha_pkg::lane_t  mix
);
    import chacha_pkg::*;

    lane_t xv;

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            sum[i] = x[i] + y[i];
            xv[i]  = z[i] ^ sum[i];
            case (op)
                OP_R16:  mix[i] = {xv[i][15:0], xv[i][31:16]};
                OP_R12:  mix[i] = {xv[i][19:0], xv[i][31:20]};
                OP_R8:   mix[i] = {xv[i][23:0], xv[i][31:24]};
                OP_R7:   mix[i] = {xv[i][24:0], xv[i][31:25]};
                default: mix[i] = xv[i];
            endcase
        end
    end

endmodule

// ----- hdl/chacha_core.sv -----
module chacha_core
#(
    parameter int DOUBLE_ROUNDS = 10
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  chacha_pkg::core_ctl_t ctl,
    input  chacha_pkg::block_t    init,
    output chacha_pkg::block_t    block,
    output chacha_pkg::core_sts_t sts
);
    import chacha_pkg::*;

    localparam int STEPS  = DOUBLE_ROUNDS * 8;
    localparam int STEP_W = $clog2(STEPS);

    typedef enum logic [1:0]
    {
        C_IDLE,
        C_ROUND,
        C_FF
    } cstate_t;

    cstate_t           state_reg;
    logic [STEP_W-1:0] step_reg;
    logic              done_reg;
    logic [31:0]       st_reg [16];

    logic       diag;
    logic [1:0] qstep;
    logic [3:0] a_idx [4];
    logic [3:0] b_idx [4];
    logic [3:0] c_idx [4];
    logic [3:0] d_idx [4];
    logic [3:0] f_idx [4];

    qr_op_t uop;
    lane_t  ux;
    lane_t  uy;
    lane_t  uz;
    lane_t  usum;
    lane_t  umix;

    assign qstep = step_reg[1:0];
    assign diag  = step_reg[2];

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            a_idx[i] = {2'b00, 2'(i)};
            b_idx[i] = {2'b01, 2'(i) + {1'b0, diag}};
            c_idx[i] = {2'b10, 2'(i) + {diag, 1'b0}};
            d_idx[i] = {2'b11, 2'(i) + {diag, diag}};
            f_idx[i] = {qstep, 2'(i)};
        end
    end

    always_comb
    begin
        case (qstep)
            2'd0:    uop = OP_R16;
            2'd1:    uop = OP_R12;
            2'd2:    uop = OP_R8;
            default: uop = OP_R7;
        endcase
        if (state_reg == C_FF)
        begin
            uop = OP_ADD;
        end
        for (int i = 0; i < 4; i++)
        begin
            if (state_reg == C_FF)
            begin
                ux[i] = st_reg[f_idx[i]];
                uy[i] = init[f_idx[i]];
                uz[i] = st_reg[f_idx[i]];
            end
            else if (!qstep[0])
            begin
                ux[i] = st_reg[a_idx[i]];
                uy[i] = st_reg[b_idx[i]];
                uz[i] = st_reg[d_idx[i]];
            end
            else
            begin
                ux[i] = st_reg[c_idx[i]];
                uy[i] = st_reg[d_idx[i]];
                uz[i] = st_reg[b_idx[i]];
            end
        end
    end

    chacha_qr_unit u_qr
    (
        .op  (uop),
        .x   (ux),
        .y   (uy),
        .z   (uz),
        .sum (usum),
        .mix (umix)
    );

    always_ff @(posedge clk)
    begin
        case (state_reg)
            C_IDLE:
            begin
                if (ctl.start)
                begin
                    for (int j = 0; j < 16; j++)
                    begin
                        st_reg[j] <= init[j];
                    end
                end
            end
            C_ROUND:
            begin
                for (int i = 0; i < 4; i++)
                begin
                    if (!qstep[0])
                    begin
                        st_reg[a_idx[i]] <= usum[i];
                        st_reg[d_idx[i]] <= umix[i];
                    end
                    else
                    begin
                        st_reg[c_idx[i]] <= usum[i];
                        st_reg[b_idx[i]] <= umix[i];
                    end
                end
            end
            C_FF:
            begin
                for (int i = 0; i < 4; i++)
                begin
                    st_reg[f_idx[i]] <= usum[i];
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= C_IDLE;
            step_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                C_IDLE:
                begin
                    if (ctl.start)
                    begin
                        state_reg <= C_ROUND;
                        step_reg  <= '0;
                    end
                end
                C_ROUND:
                begin
                    if (step_reg == STEP_W'(STEPS - 1))
                    begin
                        state_reg <= C_FF;
                        step_reg  <= '0;
                    end
                    else
                    begin
                        step_reg <= step_reg + 1'b1;
                    end
                end
                C_FF:
                begin
                    step_reg <= step_reg + 1'b1;
                    if (qstep == 2'd3)
                    begin
                        state_reg <= C_IDLE;
                        done_reg  <= 1'b1;
                    end
                end
                default:
                begin
                    state_reg <= C_IDLE;
                end
            endcase
        end
    end

    always_comb
    begin
        for (int j = 0; j < 16; j++)
        begin
            block[j] = st_reg[j];
        end
    end

    assign sts.busy = (state_reg != C_IDLE);
    assign sts.done = done_reg;

endmodule

// ----- hdl/chacha20_stream_cipher.sv -----
// Channel  Direction  Handshake           Payload
// s_*      in         s_tvalid/s_tready   s_tdata = data_in, s_tuser = restart
// m_*      out        m_tvalid/m_tready   m_tdata = data_out
// cfg_*    in         cfg_valid/cfg_ready cfg_index = register, cfg_data = value
//
// A byte served from buffered keystream gives its result in the next cycle; the next byte
// enters in the cycle the previous result transfers out, so bytes stream at one per cycle
// while m_tready is high. A byte that needs a new block (buffer empty or restart) gives its
// result after the core loads the state, runs its quarter-round steps at one per cycle on a
// shared four-lane ARX unit and adds the feed-forward; s_tready is low meanwhile.
// Reset clears the control, counter and configuration registers and empties the buffer.
module chacha20_stream_cipher
#(
    parameter int DOUBLE_ROUNDS = 10
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_in
    input  logic [0:0]  s_tuser,   // [0] restart
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] data_out
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data
);
    import chacha_pkg::*;

    typedef enum logic
    {
        T_IDLE,
        T_GEN
    } tstate_t;

    tstate_t     state_reg;
    logic        start_reg;
    logic        m_valid_reg;
    logic [7:0]  out_reg;
    logic [7:0]  hold_reg;
    logic [6:0]  pos_reg;
    logic [31:0] ctr_reg;
    logic [31:0] nwz_reg;
    logic [63:0] key_reg [4];
    logic [63:0] nonce_low_reg;
    logic [31:0] nonce_high_reg;
    logic [31:0] init_ctr_reg;

    core_ctl_t ctl;
    core_sts_t sts;
    block_t    init;
    block_t    block;

    logic        accept;
    logic        need_blk;
    logic [31:0] ks_word;
    logic [7:0]  ks_byte;

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == T_IDLE) && (!m_valid_reg || m_tready);
    assign accept    = s_tvalid && s_tready;
    assign need_blk  = s_tuser[0] || pos_reg[6];
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = out_reg;
    assign ctl.start = start_reg;

    assign ks_word = block[pos_reg[5:2]];
    assign ks_byte = ks_word[{pos_reg[1:0], 3'b000} +: 8];

    always_comb
    begin
        init[0] = SIGMA_0;
        init[1] = SIGMA_1;
        init[2] = SIGMA_2;
        init[3] = SIGMA_3;
        for (int k = 0; k < 4; k++)
        begin
            init[4 + 2 * k] = key_reg[k][31:0];
            init[5 + 2 * k] = key_reg[k][63:32];
        end
        init[12] = ctr_reg;
        init[13] = nwz_reg;
        init[14] = nonce_low_reg[63:32];
        init[15] = nonce_high_reg;
    end

    chacha_core #(.DOUBLE_ROUNDS(DOUBLE_ROUNDS)) u_core
    (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (ctl),
        .init  (init),
        .block (block),
        .sts   (sts)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < 4; k++)
            begin
                key_reg[k] <= '0;
            end
            nonce_low_reg  <= '0;
            nonce_high_reg <= '0;
            init_ctr_reg   <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_KEY_0:      key_reg[0]     <= cfg_data;
                REG_KEY_1:      key_reg[1]     <= cfg_data;
                REG_KEY_2:      key_reg[2]     <= cfg_data;
                REG_KEY_3:      key_reg[3]     <= cfg_data;
                REG_NONCE_LOW:  nonce_low_reg  <= cfg_data;
                REG_NONCE_HIGH: nonce_high_reg <= cfg_data[31:0];
                REG_INIT_CTR:   init_ctr_reg   <= cfg_data[31:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= T_IDLE;
            start_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
            pos_reg     <= 7'd64;
            ctr_reg     <= '0;
            nwz_reg     <= '0;
        end
        else
        begin
            start_reg <= 1'b0;
            if (m_valid_reg && m_tready)
            begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                T_IDLE:
                begin
                    if (accept)
                    begin
                        if (need_blk)
                        begin
                            if (s_tuser[0])
                            begin
                                ctr_reg <= init_ctr_reg;
                                nwz_reg <= nonce_low_reg[31:0];
                            end
                            pos_reg   <= '0;
                            start_reg <= 1'b1;
                            state_reg <= T_GEN;
                        end
                        else
                        begin
                            m_valid_reg <= 1'b1;
                            pos_reg     <= pos_reg + 1'b1;
                        end
                    end
                end
                T_GEN:
                begin
                    if (sts.done)
                    begin
                        m_valid_reg        <= 1'b1;
                        pos_reg            <= pos_reg + 1'b1;
                        {nwz_reg, ctr_reg} <= {nwz_reg, ctr_reg} + 64'd1;
                        state_reg          <= T_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= T_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            hold_reg <= s_tdata;
            if (!need_blk)
            begin
                out_reg <= s_tdata ^ ks_byte;
            end
        end
        else if ((state_reg == T_GEN) && sts.done)
        begin
            out_reg <= hold_reg ^ ks_byte;
        end
    end

`ifndef SYNTH
    a_done_out: assert property (@(posedge clk) disable iff (!rst_n)
        sts.done |=> m_valid_reg)
        else $error("finished block did not produce a result");

    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.start |-> !sts.busy)
        else $error("block start while core busy");

    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= 7'd64)
        else $error("buffer position out of range");

    a_hit_out: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !s_tuser[0] && !pos_reg[6]) |=> (m_valid_reg && (state_reg == T_IDLE)))
        else $error("buffered byte did not produce a result");
`endif

endmodule
